>>> rtl/qrs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrs_pkg
// Status codes and widths shared by the quadratic root solver.
// ----------------------------------------------------------------------------
package qrs_pkg;

  localparam int DISC_W = 32;
  localparam int ROOT_W = 16;
  localparam int STAT_W = 2;

  typedef enum logic [STAT_W-1:0] {
    ST_NONE   = 2'd0,
    ST_DOUBLE = 2'd1,
    ST_TWO    = 2'd2,
    ST_AZERO  = 2'd3
  } root_status_t;

endpackage

>>> rtl/quadratic_root_solver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadratic_root_solver
// Real roots of a*x^2+b*x+c, truncated toward zero, fully pipelined.
// ----------------------------------------------------------------------------
//  channel | ports                                          | direction
//  in      | in_valid/in_ready, in_coef_a/b/c               | input
//  out     | out_valid/out_ready, out_root_status,          | output
//          | out_discriminant, out_root_low, out_root_high  |
//
// One transaction per cycle while the output is not stalled. Stages in order:
// products, discriminant, square root (one result bit per stage over 16
// stages), the root numerators, a bit-per-stage divider for both roots in
// parallel (COEF_BITS + 2 stages), then the output register.
// The whole pipe advances together; a stalled output holds every stage.
// Synchronous active-low reset clears all valid bits.
// ----------------------------------------------------------------------------
module quadratic_root_solver #(
  parameter int COEF_BITS = 15
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COEF_BITS-1:0]  in_coef_a,
  input  logic signed [COEF_BITS-1:0]  in_coef_b,
  input  logic signed [COEF_BITS-1:0]  in_coef_c,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [qrs_pkg::STAT_W-1:0]   out_root_status,
  output logic signed [qrs_pkg::DISC_W-1:0] out_discriminant,
  output logic signed [qrs_pkg::ROOT_W-1:0] out_root_low,
  output logic signed [qrs_pkg::ROOT_W-1:0] out_root_high
);
  import qrs_pkg::*;

  localparam int CW    = COEF_BITS;
  localparam int SQ_W  = 16;             // floor sqrt of a 32-bit value
  localparam int NUM_W = CW + 2;         // |p| + s + 1 magnitude
  localparam int DEN_W = CW + 1;         // 2|a|
  localparam int TAG_W = STAT_W + DISC_W + 2;

  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // ---------------- stage 1: products ----------------
  logic                     s1_vld_r;
  logic signed [DISC_W-1:0] s1_bb_r, s1_ac4_r;
  logic signed [CW-1:0]     s1_a_r, s1_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_bb_r  <= DISC_W'(in_coef_b * in_coef_b);
      s1_ac4_r <= DISC_W'(in_coef_a * in_coef_c) <<< 2;
      s1_a_r   <= in_coef_a;
      s1_b_r   <= in_coef_b;
    end
  end

  // ---------------- stage 2: discriminant ----------------
  logic                     s2_vld_r;
  logic signed [DISC_W-1:0] s2_d_r;
  logic signed [CW-1:0]     s2_a_r, s2_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (en) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_d_r <= s1_bb_r - s1_ac4_r;
      s2_a_r <= s1_a_r;
      s2_b_r <= s1_b_r;
    end
  end

  // ---------------- square root pipeline ----------------
  // Stage k decides one result bit, bit weight 4^(SQ_W-1-k).
  logic [SQ_W:0]                    q_vld;
  logic [SQ_W:0][DISC_W-1:0]        q_n, q_res;
  logic [SQ_W:0][DISC_W-1:0]        q_d;
  logic [SQ_W:0][CW-1:0]            q_a, q_b;

  always_comb begin
    q_vld[0] = s2_vld_r;
    q_n[0]   = (s2_d_r < 0) ? '0 : s2_d_r;
    q_res[0] = '0;
    q_d[0]   = s2_d_r;
    q_a[0]   = s2_a_r;
    q_b[0]   = s2_b_r;
  end

  for (genvar k = 0; k < SQ_W; k++) begin : g_sqrt
    localparam logic [DISC_W-1:0] BIT = DISC_W'(1) << (2 * (SQ_W - 1 - k));
    logic [DISC_W-1:0] trial_nxt;
    logic              vld_q_r;
    logic [DISC_W-1:0] n_q_r, res_q_r, d_q_r;
    logic [CW-1:0]     a_q_r, b_q_r;

    assign trial_nxt = q_res[k] + BIT;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_q_r <= 1'b0;
      end else if (en) begin
        vld_q_r <= q_vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (q_n[k] >= trial_nxt) begin
          n_q_r   <= q_n[k] - trial_nxt;
          res_q_r <= (q_res[k] >> 1) + BIT;
        end else begin
          n_q_r   <= q_n[k];
          res_q_r <= q_res[k] >> 1;
        end
        d_q_r <= q_d[k];
        a_q_r <= q_a[k];
        b_q_r <= q_b[k];
      end
    end

    always_comb begin
      q_vld[k+1] = vld_q_r;
      q_n[k+1]   = n_q_r;
      q_res[k+1] = res_q_r;
      q_d[k+1]   = d_q_r;
      q_a[k+1]   = a_q_r;
      q_b[k+1]   = b_q_r;
    end
  end

  // ---------------- stage: numerators ----------------
  // Remainder zero means d is a perfect square.
  logic [SQ_W-1:0] sq_s;
  logic            sq_exact;
  assign sq_s     = q_res[SQ_W][SQ_W-1:0];
  assign sq_exact = (q_n[SQ_W] == '0);

  logic signed [NUM_W:0]  p_nxt, s_nxt;
  logic signed [NUM_W:0]  fl_lo_nxt, fl_hi_nxt, fl_m_nxt, fl_p_nxt;
  logic [DEN_W-1:0]       den_nxt;
  root_status_t           st_nxt;
  logic                   a_neg;

  always_comb begin
    a_neg   = q_a[SQ_W][CW-1];
    p_nxt   = a_neg ? (NUM_W+1)'($signed(q_b[SQ_W]))
                    : -(NUM_W+1)'($signed(q_b[SQ_W]));
    s_nxt   = (NUM_W+1)'({1'b0, sq_s});
    fl_p_nxt = p_nxt + s_nxt;
    fl_m_nxt = sq_exact ? (p_nxt - s_nxt) : (p_nxt - s_nxt - (NUM_W+1)'(1));
    // minus-sign root takes t = -sg: for a<0 that is the p+s branch
    fl_lo_nxt = a_neg ? fl_p_nxt : fl_m_nxt;
    fl_hi_nxt = a_neg ? fl_m_nxt : fl_p_nxt;
    den_nxt  = a_neg ? DEN_W'(-(DEN_W)'(q_a[SQ_W])) << 1
                     : DEN_W'(q_a[SQ_W]) << 1;
    priority if (q_a[SQ_W] == '0) begin
      st_nxt = ST_AZERO;
    end else if (q_d[SQ_W][DISC_W-1]) begin
      st_nxt = ST_NONE;
    end else if (q_d[SQ_W] == '0) begin
      st_nxt = ST_DOUBLE;
    end else begin
      st_nxt = ST_TWO;
    end
  end

  // Magnitude of the numerator used for truncation toward zero.
  function automatic logic [NUM_W:0] mag_num(input logic signed [NUM_W:0] fl,
                                             input logic exact);
    logic signed [NUM_W:0] ce;
    begin
      ce = exact ? fl : fl + (NUM_W+1)'(1);
      mag_num = fl[NUM_W] ? (NUM_W+1)'(-ce) : fl;
    end
  endfunction

  logic                 s3_vld_r;
  logic [NUM_W-1:0]     s3_nlo_r, s3_nhi_r;
  logic [DEN_W-1:0]     s3_den_r;
  logic [TAG_W-1:0]     s3_tag_r;
  logic [NUM_W:0]       mlo_nxt, mhi_nxt;

  always_comb begin
    // a negative floor rounds up to the ceiling unless the root is exact
    mlo_nxt = mag_num(fl_lo_nxt, sq_exact);
    mhi_nxt = mag_num(fl_hi_nxt, sq_exact);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (en) begin
      s3_vld_r <= q_vld[SQ_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_nlo_r <= mlo_nxt[NUM_W-1:0];
      s3_nhi_r <= mhi_nxt[NUM_W-1:0];
      s3_den_r <= (den_nxt == '0) ? DEN_W'(1) : den_nxt;
      s3_tag_r <= {st_nxt, q_d[SQ_W], fl_lo_nxt[NUM_W], fl_hi_nxt[NUM_W]};
    end
  end

  // ---------------- dividers ----------------
  logic             dlo_vld, dhi_vld;
  logic [NUM_W-1:0] qlo, qhi;
  logic [TAG_W-1:0] tag_o, tag_unused;

  qrs_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .TAG_W(TAG_W)) u_div_lo (
    .clk, .rst_n, .en,
    .in_vld(s3_vld_r), .in_num(s3_nlo_r), .in_den(s3_den_r), .in_tag(s3_tag_r),
    .out_vld(dlo_vld), .out_quo(qlo), .out_tag(tag_o)
  );

  qrs_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .TAG_W(TAG_W)) u_div_hi (
    .clk, .rst_n, .en,
    .in_vld(s3_vld_r), .in_num(s3_nhi_r), .in_den(s3_den_r), .in_tag(s3_tag_r),
    .out_vld(dhi_vld), .out_quo(qhi), .out_tag(tag_unused)
  );

  // ---------------- output register ----------------
  root_status_t             st_o;
  logic [DISC_W-1:0]        d_o;
  logic                     neg_lo, neg_hi, roots_on;
  logic [ROOT_W-1:0]        rlo_nxt, rhi_nxt;

  always_comb begin
    {st_o, d_o, neg_lo, neg_hi} = (dlo_vld && dhi_vld) ? tag_o : tag_unused;
    roots_on = (st_o == ST_DOUBLE) || (st_o == ST_TWO);
    rlo_nxt  = neg_lo ? -ROOT_W'(qlo) : ROOT_W'(qlo);
    rhi_nxt  = neg_hi ? -ROOT_W'(qhi) : ROOT_W'(qhi);
    if (!roots_on) begin
      rlo_nxt = '0;
      rhi_nxt = '0;
    end
  end

  logic                     out_vld_r;
  logic [STAT_W-1:0]        out_st_r;
  logic [DISC_W-1:0]        out_d_r;
  logic [ROOT_W-1:0]        out_lo_r, out_hi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= dlo_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_st_r <= st_o;
      out_d_r  <= d_o;
      out_lo_r <= rlo_nxt;
      out_hi_r <= rhi_nxt;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_root_status  = out_st_r;
  assign out_discriminant = out_d_r;
  assign out_root_low     = out_lo_r;
  assign out_root_high    = out_hi_r;

endmodule

>>> rtl/qrs_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrs_div
// Pipelined restoring divider: unsigned numerator by unsigned denominator,
// one quotient bit per stage. Payload of type tag travels alongside.
// ----------------------------------------------------------------------------
module qrs_div #(
  parameter int NUM_W = 17,
  parameter int DEN_W = 16,
  parameter int TAG_W = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_vld,
  input  logic [NUM_W-1:0] in_num,
  input  logic [DEN_W-1:0] in_den,
  input  logic [TAG_W-1:0] in_tag,
  output logic             out_vld,
  output logic [NUM_W-1:0] out_quo,
  output logic [TAG_W-1:0] out_tag
);
  import qrs_pkg::*;

  localparam int REM_W = DEN_W + 1;

  logic [NUM_W:0]            vld_r;
  logic [NUM_W:0][NUM_W-1:0] num_r;
  logic [NUM_W:0][REM_W-1:0] rem_r;
  logic [NUM_W:0][DEN_W-1:0] den_r;
  logic [NUM_W:0][TAG_W-1:0] tag_r;

  always_comb begin
    vld_r[0] = in_vld;
    num_r[0] = in_num;
    rem_r[0] = '0;
    den_r[0] = in_den;
    tag_r[0] = in_tag;
  end

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic [REM_W-1:0] sh_nxt;
    logic [REM_W:0]   diff_nxt;
    logic             vld_q_r;
    logic [NUM_W-1:0] num_q_r;
    logic [REM_W-1:0] rem_q_r;
    logic [DEN_W-1:0] den_q_r;
    logic [TAG_W-1:0] tag_q_r;

    always_comb begin
      sh_nxt   = {rem_r[k][REM_W-2:0], num_r[k][NUM_W-1]};
      diff_nxt = {1'b0, sh_nxt} - {2'b00, den_r[k]};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_q_r <= 1'b0;
      end else if (en) begin
        vld_q_r <= vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        // num register shifts out numerator bits and shifts in quotient bits
        num_q_r <= {num_r[k][NUM_W-2:0], ~diff_nxt[REM_W]};
        rem_q_r <= diff_nxt[REM_W] ? sh_nxt : diff_nxt[REM_W-1:0];
        den_q_r <= den_r[k];
        tag_q_r <= tag_r[k];
      end
    end

    always_comb begin
      vld_r[k+1] = vld_q_r;
      num_r[k+1] = num_q_r;
      rem_r[k+1] = rem_q_r;
      den_r[k+1] = den_q_r;
      tag_r[k+1] = tag_q_r;
    end
  end

  assign out_vld = vld_r[NUM_W];
  assign out_quo = num_r[NUM_W];
  assign out_tag = tag_r[NUM_W];

endmodule
